// ----- rtl/three_level_priority_arbiter_unit_assert.svh -----
// Assertion macros used by the arbiter top level.
`ifndef THREE_LEVEL_PRIORITY_ARBITER_UNIT_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_ARBITER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TLPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TLPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLPA_ASSERT(lbl, clk, rst, prop, msg)
`define TLPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/tlpa_pkg.sv -----
`default_nettype none
package tlpa_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_LEVELS  = 3;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH   = NUM_LEVELS * QUEUE_DEPTH;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int TAG_W       = 16;
  localparam int CNT_W       = 8;

  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_DISPATCH = 2'd1;
  localparam logic [1:0] CMD_FLUSH    = 2'd2;

  localparam logic [1:0] PRIO_HIGH    = 2'd0;
  localparam logic [1:0] PRIO_MED     = 2'd1;
  localparam logic [1:0] PRIO_LOW     = 2'd2;

  localparam logic [1:0] LVL_HIGH     = 2'd0;
  localparam logic [1:0] LVL_MED      = 2'd1;
  localparam logic [1:0] LVL_LOW      = 2'd2;

  localparam logic [CNT_W-1:0] GRANT_LIMIT_RESET = CNT_W'(4);

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       flush;
    logic       restart;
    logic [1:0] level;
  } dp_cmd_t;

  typedef struct packed {
    logic [NUM_LEVELS-1:0] not_empty;
    logic [NUM_LEVELS-1:0] full;
    logic                  high_ok;
    logic                  med_ok;
  } dp_status_t;

  // Each level owns one contiguous region of the shared tag RAM.
  function automatic logic [RAM_AW-1:0] level_base(input logic [1:0] lvl);
    logic [RAM_AW-1:0] base;
    unique case (lvl)
      LVL_MED: base = RAM_AW'(QUEUE_DEPTH);
      LVL_LOW: base = RAM_AW'(2 * QUEUE_DEPTH);
      default: base = '0;
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tlpa_ram.sv -----
`default_nettype none
module tlpa_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 48,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tlpa_datapath.sv -----
`default_nettype none
module tlpa_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tlpa_pkg::dp_cmd_t            dp_cmd,
  input  wire logic [tlpa_pkg::TAG_W-1:0]   request_tag,
  input  wire logic                         cfg_we,
  input  wire logic [tlpa_pkg::CNT_W-1:0]   cfg_data,
  output tlpa_pkg::dp_status_t              status,
  output logic      [tlpa_pkg::TAG_W-1:0]   grant_tag,
  output logic                              all_empty
);

  logic [tlpa_pkg::PTR_W-1:0]  rd_ptr [tlpa_pkg::NUM_LEVELS];
  logic [tlpa_pkg::PTR_W-1:0]  wr_ptr [tlpa_pkg::NUM_LEVELS];
  logic [tlpa_pkg::FILL_W-1:0] fill   [tlpa_pkg::NUM_LEVELS];
  logic [tlpa_pkg::CNT_W-1:0]  high_count;
  logic [tlpa_pkg::CNT_W-1:0]  med_count;
  logic [tlpa_pkg::CNT_W-1:0]  grant_limit;
  logic [tlpa_pkg::CNT_W-1:0]  rate_eff;
  logic                        pop_d;
  logic [tlpa_pkg::PTR_W-1:0]  rd_sel;
  logic [tlpa_pkg::PTR_W-1:0]  wr_sel;
  logic [tlpa_pkg::RAM_AW-1:0] waddr;
  logic [tlpa_pkg::RAM_AW-1:0] raddr;
  logic [tlpa_pkg::TAG_W-1:0]  rdata;

  function automatic logic [tlpa_pkg::PTR_W-1:0] ptr_inc(
    input logic [tlpa_pkg::PTR_W-1:0] p
  );
    return (p == tlpa_pkg::PTR_W'(tlpa_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // A grant limit of zero behaves as one.
  assign rate_eff = (grant_limit == '0) ? tlpa_pkg::CNT_W'(1) : grant_limit;

  always_comb begin
    rd_sel = '0;
    wr_sel = '0;
    for (int i = 0; i < tlpa_pkg::NUM_LEVELS; i++) begin
      if (dp_cmd.level == 2'(i)) begin
        rd_sel = rd_ptr[i];
        wr_sel = wr_ptr[i];
      end
      status.not_empty[i] = (fill[i] != '0);
      status.full[i]      = (fill[i] == tlpa_pkg::FILL_W'(tlpa_pkg::QUEUE_DEPTH));
    end
    status.high_ok = (high_count < rate_eff);
    status.med_ok  = (med_count < rate_eff);
  end

  assign waddr = tlpa_pkg::level_base(dp_cmd.level) + tlpa_pkg::RAM_AW'(wr_sel);
  assign raddr = tlpa_pkg::level_base(dp_cmd.level) + tlpa_pkg::RAM_AW'(rd_sel);

  tlpa_ram #(
    .WIDTH (tlpa_pkg::TAG_W),
    .DEPTH (tlpa_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (dp_cmd.push),
    .waddr (waddr),
    .wdata (request_tag),
    .re    (dp_cmd.pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tlpa_pkg::NUM_LEVELS; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        fill[i]   <= '0;
      end
      high_count  <= '0;
      med_count   <= '0;
      grant_limit <= tlpa_pkg::GRANT_LIMIT_RESET;
      pop_d       <= 1'b0;
    end else begin
      if (cfg_we) begin
        grant_limit <= cfg_data;
      end
      pop_d <= dp_cmd.pop;
      if (dp_cmd.flush) begin
        for (int i = 0; i < tlpa_pkg::NUM_LEVELS; i++) begin
          rd_ptr[i] <= '0;
          wr_ptr[i] <= '0;
          fill[i]   <= '0;
        end
        high_count <= '0;
        med_count  <= '0;
      end else if (dp_cmd.push) begin
        for (int i = 0; i < tlpa_pkg::NUM_LEVELS; i++) begin
          if (dp_cmd.level == 2'(i)) begin
            wr_ptr[i] <= ptr_inc(wr_ptr[i]);
            fill[i]   <= fill[i] + 1'b1;
          end
        end
      end else if (dp_cmd.pop) begin
        for (int i = 0; i < tlpa_pkg::NUM_LEVELS; i++) begin
          if (dp_cmd.level == 2'(i)) begin
            rd_ptr[i] <= ptr_inc(rd_ptr[i]);
            fill[i]   <= fill[i] - 1'b1;
          end
        end
        unique case (dp_cmd.level)
          tlpa_pkg::LVL_HIGH: begin
            high_count <= dp_cmd.restart ? tlpa_pkg::CNT_W'(1) : high_count + 1'b1;
            // A restart means every level with entries has used up its limit; counting begins again from zero.
            if (dp_cmd.restart) begin
              med_count <= '0;
            end
          end
          tlpa_pkg::LVL_MED: begin
            med_count  <= dp_cmd.restart ? tlpa_pkg::CNT_W'(1) : med_count + 1'b1;
            high_count <= '0;
          end
          default: begin
            high_count <= '0;
            med_count  <= '0;
          end
        endcase
      end
    end
  end

  assign grant_tag = pop_d ? rdata : '0;
  assign all_empty = (status.not_empty == '0);

endmodule
`default_nettype wire

// ----- rtl/tlpa_ctrl.sv -----
`default_nettype none
module tlpa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           cmd,
  input  wire logic [1:0]           priority_req,
  input  wire tlpa_pkg::dp_status_t status,
  output logic                      busy,
  output tlpa_pkg::dp_cmd_t         dp_cmd,
  output logic                      done,
  output logic                      push_accepted,
  output logic                      push_dropped,
  output logic                      grant_valid,
  output logic [1:0]                grant_level
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  logic       state;
  logic       state_next;
  logic       accept;
  logic [1:0] push_level;
  logic       push_accepted_next;
  logic       push_dropped_next;
  logic       grant_valid_next;
  logic [1:0] grant_level_next;

  // Every command completes without stalling, so a new beat is always welcome.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = (state == ST_RESP);

  always_comb begin
    unique case (priority_req)
      tlpa_pkg::PRIO_HIGH: push_level = tlpa_pkg::LVL_HIGH;
      tlpa_pkg::PRIO_LOW:  push_level = tlpa_pkg::LVL_LOW;
      default:             push_level = tlpa_pkg::LVL_MED;
    endcase
  end

  always_comb begin
    dp_cmd             = '0;
    push_accepted_next = 1'b0;
    push_dropped_next  = 1'b0;
    grant_valid_next   = 1'b0;
    grant_level_next   = tlpa_pkg::LVL_HIGH;
    state_next         = accept ? ST_RESP : ST_IDLE;
    if (accept) begin
      unique case (cmd)
        tlpa_pkg::CMD_PUSH: begin
          dp_cmd.level = push_level;
          if (status.full[push_level]) begin
            push_dropped_next = 1'b1;
          end else begin
            dp_cmd.push        = 1'b1;
            push_accepted_next = 1'b1;
          end
        end
        tlpa_pkg::CMD_DISPATCH: begin
          if (status.not_empty != '0) begin
            dp_cmd.pop       = 1'b1;
            grant_valid_next = 1'b1;
            priority if (status.not_empty[tlpa_pkg::LVL_HIGH] && status.high_ok) begin
              dp_cmd.level = tlpa_pkg::LVL_HIGH;
            end else if (status.not_empty[tlpa_pkg::LVL_MED] && status.med_ok) begin
              dp_cmd.level = tlpa_pkg::LVL_MED;
            end else if (status.not_empty[tlpa_pkg::LVL_LOW]) begin
              dp_cmd.level = tlpa_pkg::LVL_LOW;
            end else begin
              // Low is empty and each upper level with entries has spent its limit: start counting over.
              dp_cmd.restart = 1'b1;
              dp_cmd.level   = status.not_empty[tlpa_pkg::LVL_HIGH] ?
                               tlpa_pkg::LVL_HIGH : tlpa_pkg::LVL_MED;
            end
            grant_level_next = dp_cmd.level;
          end
        end
        tlpa_pkg::CMD_FLUSH: begin
          dp_cmd.flush = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      push_accepted <= 1'b0;
      push_dropped  <= 1'b0;
      grant_valid   <= 1'b0;
      grant_level   <= tlpa_pkg::LVL_HIGH;
    end else begin
      state         <= state_next;
      push_accepted <= push_accepted_next;
      push_dropped  <= push_dropped_next;
      grant_valid   <= grant_valid_next;
      grant_level   <= grant_level_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/three_level_priority_arbiter_unit.sv -----
`default_nettype none
// Three-queue strict-priority tag scheduler with a starvation limit. A command beat is
// taken at every clock edge where start is high and busy is low; busy never rises, so
// one push, dispatch or flush can be issued each cycle. The result of a beat appears
// on the result ports in the next cycle, for exactly one cycle, marked by done; the
// receiver cannot stall it and must capture it then. The grant tag comes from the
// registered read port of the shared tag RAM holding all three queues. all_empty
// reports the queue state after the command. cfg_ready is always high. The user must
// write the grant limit (cfg_valid/cfg_data) while no command is in flight; unchecked.
`include "three_level_priority_arbiter_unit_assert.svh"
module three_level_priority_arbiter_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 cmd,
  input  wire logic [1:0]                 priority_req,
  input  wire logic [tlpa_pkg::TAG_W-1:0] request_tag,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [tlpa_pkg::CNT_W-1:0] cfg_data,
  output logic                            done,
  output logic                            push_accepted,
  output logic                            push_dropped,
  output logic                            grant_valid,
  output logic      [tlpa_pkg::TAG_W-1:0] grant_tag,
  output logic      [1:0]                 grant_level,
  output logic                            all_empty
);

  tlpa_pkg::dp_cmd_t    dp_cmd;
  tlpa_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tlpa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .priority_req  (priority_req),
    .status        (status),
    .busy          (busy),
    .dp_cmd        (dp_cmd),
    .done          (done),
    .push_accepted (push_accepted),
    .push_dropped  (push_dropped),
    .grant_valid   (grant_valid),
    .grant_level   (grant_level)
  );

  tlpa_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .request_tag (request_tag),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .status      (status),
    .grant_tag   (grant_tag),
    .all_empty   (all_empty)
  );

  `TLPA_ASSERT(a_beat_gives_result, clk, rst, (start && !busy) |=> done, "accepted beat gave no result")
  `TLPA_ASSERT(a_flags_only_on_done, clk, rst, (push_accepted || push_dropped || grant_valid) |-> done, "result flag outside done")
  `TLPA_ASSERT(a_stored_push_not_empty, clk, rst, push_accepted |-> !all_empty, "stored push but queues empty")
  `TLPA_ASSERT_ALWAYS(a_tag_needs_grant, clk, (grant_tag != '0) |-> grant_valid, "grant_tag without grant")

endmodule
`default_nettype wire

// ----- test/tlpa_outcome_checker.sv -----
module tlpa_outcome_checker
  import tlpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic [1:0]       cmd,
  input  wire logic [1:0]       priority_req,
  input  wire logic [TAG_W-1:0] request_tag,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data,
  input  wire logic             done,
  input  wire logic             push_accepted,
  input  wire logic             push_dropped,
  input  wire logic             grant_valid,
  input  wire logic [TAG_W-1:0] grant_tag,
  input  wire logic [1:0]       grant_level,
  input  wire logic             all_empty,
  output int                    mismatch_count,
  output int                    pending_results,
  output int                    grant_count,
  output int                    drop_count
);

  typedef struct packed {
    logic             push_accepted;
    logic             push_dropped;
    logic             grant_valid;
    logic [TAG_W-1:0] grant_tag;
    logic [1:0]       grant_level;
    logic             all_empty;
  } outcome_t;

  localparam logic [1:0] LVL_NONE = 2'd3;

  logic [TAG_W-1:0] tag_ram [NUM_LEVELS][QUEUE_DEPTH];
  int               rd_ptr [NUM_LEVELS];
  int               fill [NUM_LEVELS];
  logic [CNT_W-1:0] high_run;
  logic [CNT_W-1:0] med_run;
  logic [CNT_W-1:0] grant_limit;
  outcome_t         outcomes_due [$];
  int               result_index;

  function automatic logic queues_idle();
    return fill[LVL_HIGH] == 0 && fill[LVL_MED] == 0 && fill[LVL_LOW] == 0;
  endfunction

  function automatic logic [1:0] pick_level(logic [CNT_W-1:0] rate);
    if (fill[LVL_HIGH] != 0 && high_run < rate) return LVL_HIGH;
    if (fill[LVL_MED] != 0 && med_run < rate) return LVL_MED;
    if (fill[LVL_LOW] != 0) return LVL_LOW;
    return LVL_NONE;
  endfunction

  function automatic outcome_t schedule_command(logic [1:0] op, logic [1:0] prio,
                                                logic [TAG_W-1:0] tag);
    outcome_t         o;
    logic [1:0]       lvl;
    logic [CNT_W-1:0] rate;
    o = '0;
    rate = (grant_limit == '0) ? CNT_W'(1) : grant_limit;
    case (op)
      CMD_PUSH: begin
        lvl = (prio == PRIO_HIGH) ? LVL_HIGH : (prio == PRIO_LOW) ? LVL_LOW : LVL_MED;
        if (fill[lvl] >= QUEUE_DEPTH) begin
          o.push_dropped = 1'b1;
        end else begin
          tag_ram[lvl][(rd_ptr[lvl] + fill[lvl]) % QUEUE_DEPTH] = tag;
          fill[lvl]++;
          o.push_accepted = 1'b1;
        end
      end
      CMD_DISPATCH: begin
        if (!queues_idle()) begin
          lvl = pick_level(rate);
          // Every level with entries has used up its run: start a fresh round.
          if (lvl == LVL_NONE) begin
            high_run = '0;
            med_run = '0;
            lvl = pick_level(rate);
          end
          o.grant_valid = 1'b1;
          o.grant_level = lvl;
          o.grant_tag = tag_ram[lvl][rd_ptr[lvl]];
          rd_ptr[lvl] = (rd_ptr[lvl] + 1) % QUEUE_DEPTH;
          fill[lvl]--;
          if (lvl == LVL_HIGH) begin
            high_run = high_run + 1'b1;
          end else if (lvl == LVL_MED) begin
            med_run = med_run + 1'b1;
            high_run = '0;
          end else begin
            high_run = '0;
            med_run = '0;
          end
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          rd_ptr[i] = 0;
          fill[i] = 0;
        end
        high_run = '0;
        med_run = '0;
      end
      default: ;
    endcase
    o.all_empty = queues_idle();
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rd_ptr[i] = 0;
        fill[i] = 0;
      end
      high_run = '0;
      med_run = '0;
      grant_limit = GRANT_LIMIT_RESET;
      outcomes_due.delete();
      mismatch_count = 0;
      grant_count = 0;
      drop_count = 0;
      result_index = 0;
    end else begin
      // A result leaving at this edge belongs to a beat taken earlier, so it is
      // checked before the beat taken at this same edge is predicted.
      if (done) begin
        got = {push_accepted, push_dropped, grant_valid, grant_tag, grant_level, all_empty};
        if (outcomes_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("ERROR: result %0d arrived with no command outstanding", result_index);
          mismatch_count++;
        end else begin
          want = outcomes_due.pop_front();
          if (want != got) begin
            if (mismatch_count < 10) begin
              $display("ERROR: result %0d mismatch", result_index);
              $display("  expected acc=%0b drop=%0b grant=%0b tag=%h level=%0d empty=%0b",
                       want.push_accepted, want.push_dropped, want.grant_valid,
                       want.grant_tag, want.grant_level, want.all_empty);
              $display("  actual   acc=%0b drop=%0b grant=%0b tag=%h level=%0d empty=%0b",
                       got.push_accepted, got.push_dropped, got.grant_valid,
                       got.grant_tag, got.grant_level, got.all_empty);
            end
            mismatch_count++;
          end
          if (want.grant_valid) grant_count++;
          if (want.push_dropped) drop_count++;
        end
        result_index++;
      end
      if (start && !busy)
        outcomes_due.push_back(schedule_command(cmd, priority_req, request_tag));
      if (cfg_valid && cfg_ready)
        grant_limit = cfg_data;
    end
    pending_results = outcomes_due.size();
  end

endmodule

// ----- test/three_level_priority_arbiter_unit_tb.sv -----
module three_level_priority_arbiter_unit_tb;
  import tlpa_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 220;
  localparam logic [1:0] CMD_IDLE = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       cmd = CMD_IDLE;
  logic [1:0]       priority_req = PRIO_HIGH;
  logic [TAG_W-1:0] request_tag = '0;
  logic             cfg_valid = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             busy;
  logic             cfg_ready;
  logic             done;
  logic             push_accepted;
  logic             push_dropped;
  logic             grant_valid;
  logic [TAG_W-1:0] grant_tag;
  logic [1:0]       grant_level;
  logic             all_empty;

  int mismatch_count;
  int pending_results;
  int grant_count;
  int drop_count;
  int cycle_count = 0;
  int commands_sent = 0;
  int rate_settings = 1;

  three_level_priority_arbiter_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .priority_req(priority_req), .request_tag(request_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .push_accepted(push_accepted), .push_dropped(push_dropped),
    .grant_valid(grant_valid), .grant_tag(grant_tag), .grant_level(grant_level),
    .all_empty(all_empty)
  );

  tlpa_outcome_checker grant_monitor (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .priority_req(priority_req), .request_tag(request_tag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .push_accepted(push_accepted), .push_dropped(push_dropped),
    .grant_valid(grant_valid), .grant_tag(grant_tag), .grant_level(grant_level),
    .all_empty(all_empty), .mismatch_count(mismatch_count),
    .pending_results(pending_results), .grant_count(grant_count),
    .drop_count(drop_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycle_count, pending_results);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic issue(logic [1:0] op, logic [1:0] prio, logic [TAG_W-1:0] tag);
    @(negedge clk);
    start <= 1'b1;
    cmd <= op;
    priority_req <= prio;
    request_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    commands_sent++;
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_rate(logic [CNT_W-1:0] rate);
    settle();
    hold_off(3);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= rate;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    rate_settings++;
  endtask

  // Mode 0 fills the queues, mode 1 drains them, mode 2 mixes both.
  function automatic logic [1:0] draw_op(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: return (r < 72) ? CMD_PUSH : (r < 97) ? CMD_DISPATCH : (r < 98) ? CMD_FLUSH : CMD_IDLE;
      1: return (r < 22) ? CMD_PUSH : (r < 97) ? CMD_DISPATCH : (r < 98) ? CMD_FLUSH : CMD_IDLE;
      default:
        return (r < 48) ? CMD_PUSH : (r < 95) ? CMD_DISPATCH : (r < 98) ? CMD_FLUSH : CMD_IDLE;
    endcase
  endfunction

  task automatic run_phase(int items);
    int         sent;
    int         burst;
    int         mode;
    logic [1:0] focus;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      mode = $urandom_range(2);
      // Leaning on one priority for a burst is what fills a queue to the top
      // and runs one level into its starvation limit.
      focus = 2'($urandom_range(3));
      repeat (burst) begin
        issue(draw_op(mode), $urandom_range(1) ? focus : 2'($urandom_range(3)),
              TAG_W'($urandom_range(16'hFFFF)));
        sent++;
      end
      if ($urandom_range(2) != 0) hold_off($urandom_range(1, 6));
      if ($urandom_range(15) == 0) settle();
    end
  endtask

  initial begin
    logic [CNT_W-1:0] rate_plan [6];
    rate_plan = '{CNT_W'(1), CNT_W'(255), CNT_W'(0), CNT_W'(2),
                  CNT_W'($urandom_range(3, 254)), GRANT_LIMIT_RESET};
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed opening at the reset grant limit.
    issue(CMD_DISPATCH, 2'd3, 16'hFFFF);
    issue(CMD_PUSH, PRIO_HIGH, 16'h0000);
    issue(CMD_PUSH, PRIO_HIGH, 16'hFFFF);
    issue(CMD_PUSH, PRIO_MED, 16'h5A5A);
    issue(CMD_PUSH, 2'd3, 16'hA5A5);
    issue(CMD_PUSH, PRIO_LOW, 16'h8001);
    issue(CMD_IDLE, PRIO_MED, 16'h1234);
    repeat (6) issue(CMD_DISPATCH, PRIO_LOW, 16'hFFFF);
    issue(CMD_PUSH, PRIO_HIGH, 16'h7FFE);
    issue(CMD_PUSH, PRIO_LOW, 16'h0001);
    issue(CMD_FLUSH, PRIO_LOW, 16'hFFFF);
    issue(CMD_DISPATCH, PRIO_HIGH, 16'h0000);
    hold_off(2);

    run_phase(PHASE_ITEMS);
    foreach (rate_plan[i]) begin
      write_rate(rate_plan[i]);
      run_phase(PHASE_ITEMS);
    end

    settle();
    hold_off(4);
    $display("Covered %0d commands under %0d grant limit settings:",
             commands_sent, rate_settings);
    $display("%0d grants and %0d dropped pushes", grant_count, drop_count);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tlpa_pkg.sv
rtl/tlpa_ram.sv
rtl/tlpa_datapath.sv
rtl/tlpa_ctrl.sv
rtl/three_level_priority_arbiter_unit.sv
test/tlpa_outcome_checker.sv
test/three_level_priority_arbiter_unit_tb.sv
